// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent property helpers used by the RTL; empty when SYNTHESIS is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/sie_pkg.sv =====
// ---------------------------------------------------------------------------
// sie_pkg
// Shared types and constants of the instruction executor.
// ---------------------------------------------------------------------------
`default_nettype none

package sie_pkg;

    localparam int DATA_W    = 16;
    localparam int NUM_REGS  = 8;
    localparam int RIDX_W    = $clog2(NUM_REGS);
    // Program memory depth; power of two, 2 .. 4096.
    localparam int MEM_DEPTH = 256;
    localparam int PC_W      = (MEM_DEPTH > 2) ? $clog2(MEM_DEPTH) : 1;
    localparam int IMM_W     = 8;
    localparam int OFS_W     = 12;
    localparam int NPC_W     = 8;

    typedef enum logic [1:0] {
        FMT_R0 = 2'd0,
        FMT_I  = 2'd1,
        FMT_J  = 2'd2,
        FMT_R3 = 2'd3
    } fmt_t;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_AND = 3'd2,
        OP_OR  = 3'd3,
        OP_XOR = 3'd4,
        OP_SHL = 3'd5,
        OP_SHR = 3'd6,
        OP_CMP = 3'd7
    } op_t;

    // Jump conditions and compare codes.
    localparam logic [1:0] COND_EQ = 2'd0;
    localparam logic [1:0] COND_GT = 2'd1;
    localparam logic [1:0] COND_LT = 2'd2;

    localparam logic [DATA_W-1:0] CMP_EQ = 16'h0000;
    localparam logic [DATA_W-1:0] CMP_GT = 16'h0001;
    localparam logic [DATA_W-1:0] CMP_LT = 16'h0002;

    // Register file write request.
    typedef struct packed {
        logic              en;
        logic [RIDX_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } rf_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sie_regfile.sv =====
// ---------------------------------------------------------------------------
// sie_regfile
// 8 x 16 register file, two registered read ports, one write port.
// ---------------------------------------------------------------------------
`default_nettype none

module sie_regfile (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         rd_en,
    input  wire logic [sie_pkg::RIDX_W-1:0]   rd_addr_a,
    input  wire logic [sie_pkg::RIDX_W-1:0]   rd_addr_b,
    input  wire sie_pkg::rf_wr_t              wr,
    output logic      [sie_pkg::DATA_W-1:0]   rd_data_a,
    output logic      [sie_pkg::DATA_W-1:0]   rd_data_b
);

    logic [sie_pkg::DATA_W-1:0]   mem [0:sie_pkg::NUM_REGS-1];
    // Entries never written read as zero.
    logic [sie_pkg::NUM_REGS-1:0] vld_reg;
    logic [sie_pkg::DATA_W-1:0]   rda_reg;
    logic [sie_pkg::DATA_W-1:0]   rdb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr.en)
        begin
            vld_reg[wr.addr] <= 1'b1;
        end
    end

    // Read returns the old contents on a same-address write; the caller bypasses.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rda_reg <= vld_reg[rd_addr_a] ? mem[rd_addr_a] : '0;
            rdb_reg <= vld_reg[rd_addr_b] ? mem[rd_addr_b] : '0;
        end
    end

    assign rd_data_a = rda_reg;
    assign rd_data_b = rdb_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sie_alu.sv =====
// ---------------------------------------------------------------------------
// sie_alu
// 16-bit ALU: add, sub, logic ops, shifts, unsigned three-way compare.
// ---------------------------------------------------------------------------
`default_nettype none

module sie_alu (
    input  wire sie_pkg::op_t                op,
    input  wire logic [sie_pkg::DATA_W-1:0]  a,
    input  wire logic [sie_pkg::DATA_W-1:0]  b,
    output logic      [sie_pkg::DATA_W-1:0]  y
);

    logic [3:0] sh;

    assign sh = b[3:0];   // shift amount modulo 16

    always_comb
    begin
        case (op)
            sie_pkg::OP_ADD: y = a + b;
            sie_pkg::OP_SUB: y = a - b;
            sie_pkg::OP_AND: y = a & b;
            sie_pkg::OP_OR:  y = a | b;
            sie_pkg::OP_XOR: y = a ^ b;
            sie_pkg::OP_SHL: y = a << sh;
            sie_pkg::OP_SHR: y = a >> sh;
            sie_pkg::OP_CMP:
            begin
                if (a == b)
                begin
                    y = sie_pkg::CMP_EQ;
                end
                else if (a > b)
                begin
                    y = sie_pkg::CMP_GT;
                end
                else
                begin
                    y = sie_pkg::CMP_LT;
                end
            end
            default: y = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/small_isa_instruction_executor.sv =====
// ---------------------------------------------------------------------------
// small_isa_instruction_executor
// Executes one 16-bit instruction per input beat, reports Rx and the next PC.
// ---------------------------------------------------------------------------
// One instruction beat goes in, one result beat comes out, in order. A new
// instruction can be accepted every cycle while out_stall does not hold back
// a full output register, so the sustained rate is then one beat per clock.
// A result beat passes through the execute stage and then the output
// register before it is offered. The register file is a synchronous RAM
// read at the accept edge (Rx and Ry), and the ALU result is written back
// when the instruction leaves the execute stage, so the read/write overlap
// between neighboring instructions is closed by a bypass register holding
// the most recent write. The PC and compare register are flops updated when
// the instruction leaves the execute stage; a jump in the next instruction
// therefore sees the compare value left by the one before it with no
// bubble. A result waiting behind out_stall does not block the next accept;
// in_stall rises only when the execute stage is full and the output register
// holds a beat that out_stall is holding back. The PC wraps at the program
// memory depth (a power of two); next_pc carries its low 8 bits.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module small_isa_instruction_executor (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [15:0]                 instruction_word,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic      [15:0]                 result_value,
    output logic      [sie_pkg::NPC_W-1:0]   next_pc
);

    localparam int DW = sie_pkg::DATA_W;
    localparam int PW = sie_pkg::PC_W;
    localparam int SW = sie_pkg::OFS_W + 1;   // jump sum width

    // -------- handshake --------
    logic accept;
    logic adv;            // execute stage moves into the output register

    // -------- execute stage --------
    logic        s1_vld_reg, s1_vld_next;
    logic [15:0] s1_instr_reg;

    // -------- architectural state --------
    logic [PW-1:0] pc_reg, pc_next;
    logic [DW-1:0] cmp_reg;

    // -------- bypass of the most recent register write --------
    logic                       fwd_vld_reg;
    logic [sie_pkg::RIDX_W-1:0] fwd_addr_reg;
    logic [DW-1:0]              fwd_data_reg;

    // -------- output register --------
    logic                      out_vld_reg, out_vld_next;
    logic [DW-1:0]             result_reg;
    logic [sie_pkg::NPC_W-1:0] npc_reg;

    // -------- decode / datapath --------
    sie_pkg::fmt_t              fmt;
    sie_pkg::op_t               op;
    logic [sie_pkg::RIDX_W-1:0] rx, ry;
    logic [1:0]                 cond;
    logic [sie_pkg::OFS_W-1:0]  offset;
    logic [DW-1:0]              rf_a, rf_b;
    logic [DW-1:0]              opnd_a, opnd_b, alu_b, alu_y;
    logic [DW-1:0]              want;
    logic                       taken;
    logic [SW-1:0]              jump_sum;
    logic [DW-1:0]              rx_after;
    sie_pkg::rf_wr_t            rf_wr;

    // Execute stage may hand off when the output register is free or draining.
    assign adv      = !out_vld_reg || !out_stall;
    assign in_stall = s1_vld_reg && !adv;
    assign accept   = in_valid && !in_stall;

    // Register file: read addresses come straight from the input beat.
    sie_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr_a (instruction_word[15:13]),
        .rd_addr_b (instruction_word[12:10]),
        .wr        (rf_wr),
        .rd_data_a (rf_a),
        .rd_data_b (rf_b)
    );

    // Decode of the instruction held in execute.
    assign fmt    = sie_pkg::fmt_t'(s1_instr_reg[1:0]);
    assign op     = sie_pkg::op_t'(s1_instr_reg[4:2]);
    assign rx     = s1_instr_reg[15:13];
    assign ry     = s1_instr_reg[12:10];
    assign cond   = s1_instr_reg[3:2];
    assign offset = s1_instr_reg[15:4];

    // RAM data is one write stale when the previous instruction wrote that reg.
    assign opnd_a = (fwd_vld_reg && (fwd_addr_reg == rx)) ? fwd_data_reg : rf_a;
    assign opnd_b = (fwd_vld_reg && (fwd_addr_reg == ry)) ? fwd_data_reg : rf_b;

    // I-type uses the zero-extended 8-bit immediate.
    assign alu_b = (fmt == sie_pkg::FMT_I) ? DW'(s1_instr_reg[12:5]) : opnd_b;

    sie_alu u_alu (
        .op (op),
        .a  (opnd_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    // Jump condition: code 3 falls back to equal.
    always_comb
    begin
        case (cond)
            sie_pkg::COND_GT: want = sie_pkg::CMP_GT;
            sie_pkg::COND_LT: want = sie_pkg::CMP_LT;
            default:          want = sie_pkg::CMP_EQ;
        endcase
    end

    assign taken    = (cmp_reg == want);
    assign jump_sum = SW'(pc_reg) + SW'(offset);

    // Next PC and register write-back.
    always_comb
    begin
        pc_next    = pc_reg + PW'(1);
        rx_after   = alu_y;
        rf_wr.en   = s1_vld_reg && adv;
        rf_wr.addr = rx;
        rf_wr.data = alu_y;
        case (fmt) inside
            sie_pkg::FMT_J:
            begin
                rf_wr.en = 1'b0;
                rx_after = opnd_a;
                if (taken)
                begin
                    pc_next = jump_sum[PW-1:0];
                end
            end
            sie_pkg::FMT_I, sie_pkg::FMT_R0, sie_pkg::FMT_R3:
            begin
                rx_after = alu_y;
            end
            default:
            begin
                rx_after = alu_y;
            end
        endcase
    end

    // -------- control registers --------
    always_comb
    begin
        s1_vld_next = s1_vld_reg;
        if (accept)
        begin
            s1_vld_next = 1'b1;
        end
        else if (adv)
        begin
            s1_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (s1_vld_reg && adv)
        begin
            out_vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            fwd_vld_reg <= 1'b0;
            pc_reg      <= '0;
            cmp_reg     <= '0;
        end
        else
        begin
            s1_vld_reg  <= s1_vld_next;
            out_vld_reg <= out_vld_next;
            if (rf_wr.en)
            begin
                fwd_vld_reg <= 1'b1;
            end
            if (s1_vld_reg && adv)
            begin
                pc_reg  <= pc_next;
                cmp_reg <= rx_after;
            end
        end
    end

    // -------- payload registers --------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_instr_reg <= instruction_word;
        end
        if (rf_wr.en)
        begin
            fwd_addr_reg <= rf_wr.addr;
            fwd_data_reg <= rf_wr.data;
        end
        if (s1_vld_reg && adv)
        begin
            result_reg <= rx_after;
            npc_reg    <= sie_pkg::NPC_W'(pc_next);
        end
    end

    assign out_valid    = out_vld_reg;
    assign result_value = result_reg;
    assign next_pc      = npc_reg;

    // -------- assertions --------
    // A written register shows up as the next result.
    `ASSERT_NEXT(a_wr_is_result, clk, rst_n, rf_wr.en, result_value == $past(rf_wr.data))
    // Compare register always mirrors the pending result.
    `ASSERT_IMPLIES(a_cmp_tracks, clk, rst_n, out_vld_reg, cmp_reg == result_reg)
    // PC moves only when an instruction retires.
    `ASSERT_NEXT(a_pc_hold, clk, rst_n, !(s1_vld_reg && adv), $stable(pc_reg))

endmodule

`default_nettype wire
